@@ sv/prf_pkg.sv @@
package prf_pkg;

    // Default coordinate width of the command fields.
    localparam int COORD_BITS_DEF = 12;

    // Fixed register widths.
    localparam int DIM_W   = 12;
    localparam int PITCH_W = 13;
    localparam int ADDR_W  = 32;
    localparam int COLOR_W = 32;
    localparam int FILL_W  = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_PIX_FMT         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_BACK_BUFFER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_COLOR      = 3'd6;

    // Register reset values.
    localparam logic               RST_PIX_FMT         = 1'b1;
    localparam logic [DIM_W-1:0]   RST_SCREEN_WIDTH    = 12'd1920;
    localparam logic [DIM_W-1:0]   RST_SCREEN_HEIGHT   = 12'd1080;
    localparam logic [PITCH_W-1:0] RST_ROW_PITCH       = 13'd1920;
    localparam logic               RST_USE_BACK_BUFFER = 1'b0;
    localparam logic [ADDR_W-1:0]  RST_FRAME_BASE      = 32'd0;
    localparam logic [FILL_W-1:0]  RST_RECT_COLOR      = 24'd0;

    // Pixel format codes.
    localparam logic FMT_RGB = 1'b0;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_IMAGE = 2'd2
    } t_cmd;

    typedef struct packed {
        logic               pix_fmt;
        logic [DIM_W-1:0]   screen_width;
        logic [DIM_W-1:0]   screen_height;
        logic [PITCH_W-1:0] row_pitch;
        logic               use_back_buffer;
        logic [ADDR_W-1:0]  frame_base;
        logic [FILL_W-1:0]  rect_color;
    } t_cfg;

    // Per-item status from the rectangle walker.
    typedef struct packed {
        logic fill_write;  // a rectangle pixel is due for this item
        logic image;       // item is an image pixel
        logic busy;
        logic last;
    } t_walk_stat;

    // Color conversion to the native layout; the red-green-blue format folds
    // red and green into the low byte and moves blue up one byte.
    function automatic logic [COLOR_W-1:0] to_native(
        input logic                fmt,
        input logic [COLOR_W-1:0]  c
    );
        logic [COLOR_W-1:0] res;
        if (fmt == FMT_RGB) begin
            res = {16'd0, c[7:0], c[23:16] | c[15:8]};
        end else begin
            res = c;
        end
        return res;
    endfunction

endpackage

@@ sv/prf_cmd_if.sv @@
interface prf_cmd_if #(
    parameter int COORD_BITS = prf_pkg::COORD_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    command;
    logic [COORD_BITS-1:0]         pos_x;
    logic [COORD_BITS-1:0]         pos_y;
    logic [COORD_BITS-1:0]         rect_width;
    logic [COORD_BITS-1:0]         rect_height;
    logic [prf_pkg::COLOR_W-1:0]   pixel_color;

    modport source (
        output valid, command, pos_x, pos_y, rect_width, rect_height, pixel_color,
        input  ready
    );
    modport sink (
        input  valid, command, pos_x, pos_y, rect_width, rect_height, pixel_color,
        output ready
    );
endinterface

@@ sv/prf_wr_if.sv @@
interface prf_wr_if;
    logic                          valid;
    logic                          ready;
    logic                          write_valid;
    logic [prf_pkg::ADDR_W-1:0]    write_offset;
    logic [prf_pkg::COLOR_W-1:0]   write_color;
    logic                          busy_res;
    logic                          last;

    modport source (
        output valid, write_valid, write_offset, write_color, busy_res, last,
        input  ready
    );
    modport sink (
        input  valid, write_valid, write_offset, write_color, busy_res, last,
        output ready
    );
endinterface

@@ sv/prf_cfg_regs.sv @@
module prf_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [prf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [prf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output prf_pkg::t_cfg                     o_cfg
);
    import prf_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PIX_FMT:         n_cfg.pix_fmt         = i_cfg_data[0];
                CFG_SCREEN_WIDTH:    n_cfg.screen_width    = i_cfg_data[DIM_W-1:0];
                CFG_SCREEN_HEIGHT:   n_cfg.screen_height   = i_cfg_data[DIM_W-1:0];
                CFG_ROW_PITCH:       n_cfg.row_pitch       = i_cfg_data[PITCH_W-1:0];
                CFG_USE_BACK_BUFFER: n_cfg.use_back_buffer = i_cfg_data[0];
                CFG_FRAME_BASE:      n_cfg.frame_base      = i_cfg_data[ADDR_W-1:0];
                CFG_RECT_COLOR:      n_cfg.rect_color      = i_cfg_data[FILL_W-1:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pix_fmt         <= RST_PIX_FMT;
            r_cfg.screen_width    <= RST_SCREEN_WIDTH;
            r_cfg.screen_height   <= RST_SCREEN_HEIGHT;
            r_cfg.row_pitch       <= RST_ROW_PITCH;
            r_cfg.use_back_buffer <= RST_USE_BACK_BUFFER;
            r_cfg.frame_base      <= RST_FRAME_BASE;
            r_cfg.rect_color      <= RST_RECT_COLOR;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ sv/prf_rect_walker.sv @@
module prf_rect_walker #(
    parameter int COORD_BITS = prf_pkg::COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic [1:0]              i_command,
    input  logic [COORD_BITS-1:0]   i_pos_x,
    input  logic [COORD_BITS-1:0]   i_pos_y,
    input  logic [COORD_BITS-1:0]   i_rect_width,
    input  logic [COORD_BITS-1:0]   i_rect_height,
    output logic [COORD_BITS:0]     o_x,
    output logic [COORD_BITS:0]     o_y,
    output prf_pkg::t_walk_stat     o_stat
);
    import prf_pkg::*;

    localparam int CUR_W = COORD_BITS + 1;

    logic                  r_active, n_active;
    logic [CUR_W-1:0]      r_cur_x, n_cur_x;
    logic [CUR_W-1:0]      r_cur_y, n_cur_y;
    logic [COORD_BITS-1:0] r_start_row, n_start_row;
    logic [CUR_W-1:0]      r_end_x, n_end_x;
    logic [CUR_W-1:0]      r_end_y, n_end_y;

    logic at_end_y;
    logic at_end;

    assign at_end_y = (r_cur_y == r_end_y);
    assign at_end   = at_end_y && (r_cur_x == r_end_x);

    always_comb begin
        n_active    = r_active;
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_start_row = r_start_row;
        n_end_x     = r_end_x;
        n_end_y     = r_end_y;
        o_stat      = '0;
        o_x         = {1'b0, i_pos_x};
        o_y         = {1'b0, i_pos_y};
        case (i_command)
            CMD_START: begin
                n_cur_x     = {1'b0, i_pos_x};
                n_cur_y     = {1'b0, i_pos_y};
                n_start_row = i_pos_y;
                n_end_x     = {1'b0, i_pos_x} + {1'b0, i_rect_width};
                n_end_y     = {1'b0, i_pos_y} + {1'b0, i_rect_height};
                n_active    = 1'b1;
                o_stat.busy = 1'b1;
            end
            CMD_STEP: begin
                o_x = r_cur_x;
                o_y = r_cur_y;
                if (r_active) begin
                    o_stat.fill_write = 1'b1;
                    if (at_end) begin
                        o_stat.last = 1'b1;
                        n_active    = 1'b0;
                    end else if (at_end_y) begin
                        n_cur_y = {1'b0, r_start_row};
                        n_cur_x = r_cur_x + 1'b1;
                    end else begin
                        n_cur_y = r_cur_y + 1'b1;
                    end
                end
                o_stat.busy = n_active;
            end
            CMD_IMAGE: begin
                o_stat.image = 1'b1;
                o_stat.busy  = r_active;
            end
            default: begin
                o_stat.busy = r_active;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_start_row <= '0;
            r_end_x     <= '0;
            r_end_y     <= '0;
        end else if (i_adv) begin
            r_active    <= n_active;
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_start_row <= n_start_row;
            r_end_x     <= n_end_x;
            r_end_y     <= n_end_y;
        end
    end

endmodule

@@ sv/prf_pixel_unit.sv @@
module prf_pixel_unit #(
    parameter int COORD_BITS = prf_pkg::COORD_BITS_DEF
) (
    input  prf_pkg::t_cfg                  i_cfg,
    input  prf_pkg::t_walk_stat            i_stat,
    input  logic [COORD_BITS:0]            i_x,
    input  logic [COORD_BITS:0]            i_y,
    input  logic [prf_pkg::COLOR_W-1:0]    i_pixel_color,
    output logic                           o_write_valid,
    output logic [prf_pkg::ADDR_W-1:0]     o_write_offset,
    output logic [prf_pkg::COLOR_W-1:0]    o_write_color
);
    import prf_pkg::*;

    localparam int PROD_W = PITCH_W + COORD_BITS + 1;

    logic [PITCH_W-1:0] pitch;
    logic [PROD_W-1:0]  prod;
    logic [ADDR_W-1:0]  index;
    logic [COLOR_W-1:0] fill_native;
    logic [COLOR_W-1:0] image_native;
    logic               in_bounds;
    logic               want;

    assign pitch = i_cfg.use_back_buffer ? {1'b0, i_cfg.screen_width} : i_cfg.row_pitch;
    assign prod  = PROD_W'(pitch) * PROD_W'(i_y);
    assign index = ADDR_W'(prod) + ADDR_W'(i_x);

    assign in_bounds = (ADDR_W'(i_x) < ADDR_W'(i_cfg.screen_width))
                    && (ADDR_W'(i_y) < ADDR_W'(i_cfg.screen_height));

    assign fill_native  = to_native(i_cfg.pix_fmt, COLOR_W'(i_cfg.rect_color));
    assign image_native = to_native(i_cfg.pix_fmt, i_pixel_color);

    // Image pixels with a zero low byte are treated as transparent.
    assign want = i_stat.fill_write || (i_stat.image && (image_native[7:0] != 8'd0));

    assign o_write_valid  = want && in_bounds;
    assign o_write_offset = o_write_valid
                          ? (i_cfg.frame_base + {index[ADDR_W-3:0], 2'b00}) : '0;
    assign o_write_color  = !o_write_valid ? '0
                          : (i_stat.image ? image_native : fill_native);

endmodule

@@ sv/pixel_rect_fill_and_blit_core.sv @@
// Framebuffer write generator for rectangle fills and image blits. A start
// command loads an inclusive rectangle, and each following step command
// produces one pixel write of the fill color, walking down each column (y
// innermost) before moving right, with last set on the final pixel. An image
// pixel command converts its color word for the pixel format and writes it
// unless the low byte of the converted color is zero. Pixels outside the
// visible screen produce a result with write_valid low, but still advance the
// rectangle walk. Every command returns exactly one result item. The block
// takes one item per clock while the output is not stalled: the item is
// captured in an input register, then the rectangle cursor update, the pitch
// times row multiply with the address add, and the color conversion all
// complete into the result register. While a finished result waits on the
// output, a new item is still taken if the input register is empty.
// Configuration registers are written through the plain write port and should
// only be changed while no items are in flight.
module pixel_rect_fill_and_blit_core #(
    parameter int COORD_BITS = prf_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [prf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [prf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    prf_cmd_if.sink                           i_cmd,
    prf_wr_if.source                          o_wr
);
    import prf_pkg::*;

    // Input register.
    logic                  r_in_valid;
    logic [1:0]            r_command;
    logic [COORD_BITS-1:0] r_pos_x;
    logic [COORD_BITS-1:0] r_pos_y;
    logic [COORD_BITS-1:0] r_rect_width;
    logic [COORD_BITS-1:0] r_rect_height;
    logic [COLOR_W-1:0]    r_pixel_color;

    // Result register.
    logic                  r_out_valid;
    logic                  r_write_valid;
    logic [ADDR_W-1:0]     r_write_offset;
    logic [COLOR_W-1:0]    r_write_color;
    logic                  r_busy_res;
    logic                  r_last;

    t_cfg                  cfg;
    t_walk_stat            stat;
    logic [COORD_BITS:0]   pix_x;
    logic [COORD_BITS:0]   pix_y;
    logic                  n_write_valid;
    logic [ADDR_W-1:0]     n_write_offset;
    logic [COLOR_W-1:0]    n_write_color;

    logic out_free;
    logic in_take;
    logic adv;

    // The result register can load when it is empty or being drained.
    assign out_free = !r_out_valid || o_wr.ready;
    assign adv      = r_in_valid && out_free;
    assign i_cmd.ready = !r_in_valid || out_free;
    assign in_take  = i_cmd.valid && i_cmd.ready;

    prf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // The rectangle state only moves when the item in the input register
    // is handed to the result register.
    prf_rect_walker #(
        .COORD_BITS (COORD_BITS)
    ) u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_command     (r_command),
        .i_pos_x       (r_pos_x),
        .i_pos_y       (r_pos_y),
        .i_rect_width  (r_rect_width),
        .i_rect_height (r_rect_height),
        .o_x           (pix_x),
        .o_y           (pix_y),
        .o_stat        (stat)
    );

    prf_pixel_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_pix (
        .i_cfg          (cfg),
        .i_stat         (stat),
        .i_x            (pix_x),
        .i_y            (pix_y),
        .i_pixel_color  (r_pixel_color),
        .o_write_valid  (n_write_valid),
        .o_write_offset (n_write_offset),
        .o_write_color  (n_write_color)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_command     <= i_cmd.command;
            r_pos_x       <= i_cmd.pos_x;
            r_pos_y       <= i_cmd.pos_y;
            r_rect_width  <= i_cmd.rect_width;
            r_rect_height <= i_cmd.rect_height;
            r_pixel_color <= i_cmd.pixel_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_write_valid  <= n_write_valid;
            r_write_offset <= n_write_offset;
            r_write_color  <= n_write_color;
            r_busy_res     <= stat.busy;
            r_last         <= stat.last;
        end
    end

    assign o_wr.valid        = r_out_valid;
    assign o_wr.write_valid  = r_write_valid;
    assign o_wr.write_offset = r_write_offset;
    assign o_wr.write_color  = r_write_color;
    assign o_wr.busy_res     = r_busy_res;
    assign o_wr.last         = r_last;

endmodule

@@ verif/tb.sv @@
// Self-checking bench for the rectangle fill and image blit write generator.
// A driver and a monitor run as clocked always blocks. The main initial block
// fills a backlog of command items, and the driver feeds them to the block one
// at a time. Every accepted command goes through a bench-side copy of the
// block's behavior, and the write it must produce is queued. Each write item
// that leaves the block is checked against the oldest queued write.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import prf_pkg::*;

    localparam int CB = COORD_BITS_DEF;

    // The command field is two bits wide, and the fourth code means nothing
    // to the block. It must still return one idle write item for it.
    localparam logic [1:0] CMD_NOP = 2'd3;

    localparam int SEG_ITEMS = 155;
    localparam int CYCLE_LIMIT = 250000;
    localparam int END_GRACE = 5000;

    typedef struct {
        logic [1:0]    cmd;
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic [CB-1:0] w;
        logic [CB-1:0] h;
        logic [31:0]   color;
    } t_cmd_item;

    typedef struct {
        logic        wv;
        logic [31:0] offset;
        logic [31:0] color;
        logic        busy;
        logic        last;
    } t_pixel_write;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    prf_cmd_if #(.COORD_BITS(CB)) cmd_if ();
    prf_wr_if wr_if ();

    pixel_rect_fill_and_blit_core #(.COORD_BITS(CB)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd_if),
        .o_wr        (wr_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Commands waiting to be driven, and writes that the block still owes us.
    t_cmd_item    cmd_backlog[$];
    t_pixel_write pending_writes[$];

    int mismatches = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit cmd_taken = 1'b0;

    // Shadow copy of the register file, kept in step with every register write.
    t_cfg cfg_shadow = '{
        pix_fmt:         RST_PIX_FMT,
        screen_width:    RST_SCREEN_WIDTH,
        screen_height:   RST_SCREEN_HEIGHT,
        row_pitch:       RST_ROW_PITCH,
        use_back_buffer: RST_USE_BACK_BUFFER,
        frame_base:      RST_FRAME_BASE,
        rect_color:      RST_RECT_COLOR
    };

    // Shadow of the rectangle walker. The cursor and end points are one bit
    // wider than a coordinate, so a rectangle that runs past the last column
    // or row keeps counting instead of wrapping.
    logic          rect_on = 1'b0;
    logic [CB:0]   cur_x = '0;
    logic [CB:0]   cur_y = '0;
    logic [CB:0]   end_x = '0;
    logic [CB:0]   end_y = '0;
    logic [CB-1:0] first_row = '0;

    // In the red-green-blue format, red and green are ORed into the low byte
    // and blue moves up one byte. The other format passes the word through.
    function automatic logic [31:0] conv_color(logic [31:0] c);
        logic [31:0] folded;
        folded = ((c >> 16) & 32'hFF) | ((c >> 8) & 32'hFF) | ((c & 32'hFF) << 8);
        return (cfg_shadow.pix_fmt == FMT_RGB) ? folded : c;
    endfunction

    function automatic bit on_screen(logic [CB:0] x, logic [CB:0] y);
        return (x < cfg_shadow.screen_width) && (y < cfg_shadow.screen_height);
    endfunction

    // Byte address of a pixel. Everything is done in 32 bits, so the sum
    // wraps the same way the hardware adder does.
    function automatic logic [31:0] pixel_addr(logic [CB:0] x, logic [CB:0] y);
        logic [31:0] pitch;
        pitch = cfg_shadow.use_back_buffer ? 32'(cfg_shadow.screen_width)
                                           : 32'(cfg_shadow.row_pitch);
        return cfg_shadow.frame_base + ((pitch * 32'(y) + 32'(x)) << 2);
    endfunction

    // Works out the write item for one accepted command and moves the
    // rectangle shadow along.
    function automatic t_pixel_write predict_pixel_write(t_cmd_item it);
        t_pixel_write r;
        logic [31:0] conv;
        r = '{wv: 1'b0, offset: '0, color: '0, busy: rect_on, last: 1'b0};
        case (it.cmd)
            CMD_START: begin
                // A new start simply replaces any rectangle still in progress.
                cur_x = (CB+1)'(it.x);
                cur_y = (CB+1)'(it.y);
                first_row = it.y;
                end_x = (CB+1)'(it.x) + (CB+1)'(it.w);
                end_y = (CB+1)'(it.y) + (CB+1)'(it.h);
                rect_on = 1'b1;
                r.busy = 1'b1;
            end
            CMD_STEP: begin
                if (rect_on) begin
                    // An off-screen pixel is not written but still uses up a step.
                    if (on_screen(cur_x, cur_y)) begin
                        r.wv = 1'b1;
                        r.offset = pixel_addr(cur_x, cur_y);
                        r.color = conv_color(32'(cfg_shadow.rect_color));
                    end
                    if (cur_x == end_x && cur_y == end_y) begin
                        r.last = 1'b1;
                        rect_on = 1'b0;
                    end else if (cur_y == end_y) begin
                        cur_y = (CB+1)'(first_row);
                        cur_x = cur_x + 1'b1;
                    end else begin
                        cur_y = cur_y + 1'b1;
                    end
                end
                r.busy = rect_on;
            end
            CMD_IMAGE: begin
                // Image pixels whose converted low byte is zero act as
                // transparent and are dropped.
                conv = conv_color(it.color);
                if (conv[7:0] != 8'h00 && on_screen((CB+1)'(it.x), (CB+1)'(it.y))) begin
                    r.wv = 1'b1;
                    r.offset = pixel_addr((CB+1)'(it.x), (CB+1)'(it.y));
                    r.color = conv;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic log_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] %s: got 0x%08h, wanted 0x%08h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Timeout guard, in a process of its own.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Monitor. Both sides are sampled at the rising edge, before the block's
    // registers update. A write item is checked first. After that the command
    // item accepted on the same edge, if any, is predicted. With the input and the
    // result register in between, a command never meets its own write on one edge.
    always @(posedge i_clk) begin
        t_cmd_item    seen;
        t_pixel_write got;
        t_pixel_write want;
        if (i_rst_n) begin
            if (wr_if.valid && wr_if.ready) begin
                got = '{wv: wr_if.write_valid, offset: wr_if.write_offset,
                        color: wr_if.write_color, busy: wr_if.busy_res, last: wr_if.last};
                if (pending_writes.size() == 0) begin
                    log_mismatch("write item with nothing expected", got.offset, '0);
                end else begin
                    want = pending_writes.pop_front();
                    if (got.wv !== want.wv)
                        log_mismatch("write_valid", 32'(got.wv), 32'(want.wv));
                    if (got.offset !== want.offset)
                        log_mismatch("write_offset", got.offset, want.offset);
                    if (got.color !== want.color)
                        log_mismatch("write_color", got.color, want.color);
                    if (got.busy !== want.busy)
                        log_mismatch("busy_res", 32'(got.busy), 32'(want.busy));
                    if (got.last !== want.last)
                        log_mismatch("last", 32'(got.last), 32'(want.last));
                end
            end
            cmd_taken = cmd_if.valid && cmd_if.ready;
            if (cmd_taken) begin
                seen = '{cmd: cmd_if.command, x: cmd_if.pos_x, y: cmd_if.pos_y,
                         w: cmd_if.rect_width, h: cmd_if.rect_height,
                         color: cmd_if.pixel_color};
                pending_writes.push_back(predict_pixel_write(seen));
            end
        end else begin
            cmd_taken = 1'b0;
        end
    end

    // Command driver. It works on the falling edge. A valid command stays on
    // the bus until it is taken. Only after that is the next one loaded or a
    // gap inserted.
    always @(negedge i_clk) begin
        t_cmd_item it;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_taken) begin
            if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                it = cmd_backlog.pop_front();
                cmd_if.command     <= it.cmd;
                cmd_if.pos_x       <= it.x;
                cmd_if.pos_y       <= it.y;
                cmd_if.rect_width  <= it.w;
                cmd_if.rect_height <= it.h;
                cmd_if.pixel_color <= it.color;
                cmd_if.valid       <= 1'b1;
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // Write side back-pressure. The stall rate is set per phase.
    always @(negedge i_clk) begin
        wr_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic push_cmd(logic [1:0] c, int x, int y, int w, int h, logic [31:0] color);
        cmd_backlog.push_back('{cmd: c, x: CB'(x), y: CB'(y), w: CB'(w), h: CB'(h),
                                color: color});
    endtask

    // Picks a coordinate, mostly inside the visible area or close to its edge.
    // Now and then it picks one at the top of the field or anywhere in it.
    function automatic int pick_coord(int lim);
        int r;
        int top;
        r = $urandom_range(0, 9);
        top = (1 << CB) - 1;
        if (r < 1) return $urandom_range(0, top);
        if (r < 2) return $urandom_range(top - 5, top);
        if (r < 7 || lim == 0) return $urandom_range(0, (lim > top) ? top : lim);
        return $urandom_range((lim > 3) ? lim - 3 : 0, (lim + 3 > top) ? top : lim + 3);
    endfunction

    // An image pixel. About a third of the time either the low byte or the red and
    // green bytes are cleared, which makes the pixel transparent in one format.
    task automatic push_image_pixel();
        logic [31:0] color;
        int pick;
        color = $urandom;
        pick = $urandom_range(0, 5);
        if (pick == 0) color = color & 32'hFFFF_FF00;
        if (pick == 1) color = color & 32'hFF00_00FF;
        push_cmd(CMD_IMAGE, pick_coord(cfg_shadow.screen_width),
                 pick_coord(cfg_shadow.screen_height), $urandom, $urandom, color);
    endtask

    // An item that leaves the rectangle walk alone: an image pixel or the
    // unused command code.
    task automatic push_side_item();
        if ($urandom_range(0, 2) == 0)
            push_cmd(CMD_NOP, $urandom, $urandom, $urandom, $urandom, $urandom);
        else
            push_image_pixel();
    endtask

    task automatic queue_random_traffic(int n_items);
        int added;
        int r;
        int w;
        int h;
        int steps;
        added = 0;
        while (added < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                // A complete rectangle, walked to its last pixel. Side items
                // are mixed in, and sometimes a spare step follows the end.
                w = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 9) : $urandom_range(0, 3);
                h = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 9) : $urandom_range(0, 3);
                push_cmd(CMD_START, pick_coord(cfg_shadow.screen_width),
                         pick_coord(cfg_shadow.screen_height), w, h, $urandom);
                added++;
                steps = (w + 1) * (h + 1) + $urandom_range(0, 1);
                repeat (steps) begin
                    if ($urandom_range(0, 9) == 0) begin
                        push_side_item();
                        added++;
                    end
                    push_cmd(CMD_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
                    added++;
                end
            end else if (r < 85) begin
                push_image_pixel();
                added++;
            end else if (r < 92) begin
                // A start with extents anywhere in the field. It gets a few
                // steps and is then dropped when the next start replaces it.
                push_cmd(CMD_START, $urandom, $urandom, $urandom, $urandom, $urandom);
                added++;
                repeat ($urandom_range(0, 4)) begin
                    push_cmd(CMD_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
                    added++;
                end
            end else begin
                if ($urandom_range(0, 1) == 0)
                    push_cmd(CMD_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
                else
                    push_side_item();
                added++;
            end
        end
    endtask

    // Waits until every command is taken and every write has come back. Then
    // it idles on so that the two-stage pipe is surely empty.
    task automatic wait_until_quiet();
        do @(negedge i_clk);
        while (cmd_backlog.size() != 0 || cmd_if.valid || pending_writes.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            CFG_PIX_FMT:         cfg_shadow.pix_fmt         = value[0];
            CFG_SCREEN_WIDTH:    cfg_shadow.screen_width    = value[DIM_W-1:0];
            CFG_SCREEN_HEIGHT:   cfg_shadow.screen_height   = value[DIM_W-1:0];
            CFG_ROW_PITCH:       cfg_shadow.row_pitch       = value[PITCH_W-1:0];
            CFG_USE_BACK_BUFFER: cfg_shadow.use_back_buffer = value[0];
            CFG_FRAME_BASE:      cfg_shadow.frame_base      = value;
            CFG_RECT_COLOR:      cfg_shadow.rect_color      = value[FILL_W-1:0];
            default: begin
            end
        endcase
    endtask

    // Rewrites the whole register file. Only call this with the block idle.
    task automatic apply_setting(bit fmt, int sw, int sh, int pitch, bit back_buf,
                                 logic [31:0] base, logic [31:0] fill);
        set_reg(CFG_PIX_FMT, 32'(fmt));
        set_reg(CFG_SCREEN_WIDTH, 32'(sw));
        set_reg(CFG_SCREEN_HEIGHT, 32'(sh));
        set_reg(CFG_ROW_PITCH, 32'(pitch));
        set_reg(CFG_USE_BACK_BUFFER, 32'(back_buf));
        set_reg(CFG_FRAME_BASE, base);
        set_reg(CFG_RECT_COLOR, fill);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        repeat (2) @(negedge i_clk);
    endtask

    initial begin
        int seg;
        int guard;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        cmd_if.valid = 1'b0;
        cmd_if.command = CMD_STEP;
        cmd_if.pos_x = '0;
        cmd_if.pos_y = '0;
        cmd_if.rect_width = '0;
        cmd_if.rect_height = '0;
        cmd_if.pixel_color = '0;
        wr_if.ready = 1'b0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items, run with the reset register values (1920 by 1080,
        // pass-through format, fill color zero, base zero).
        send_idle_pct = 28;
        recv_idle_pct = 87;
        // A step with no rectangle, then the unused command code.
        push_cmd(CMD_STEP, 0, 0, 0, 0, 0);
        push_cmd(CMD_NOP, 4095, 4095, 4095, 4095, 32'hFFFF_FFFF);
        // Image pixels: all ones, a transparent pixel, the far corner of the
        // field, the last visible pixel, and the first column and row past the edge.
        push_cmd(CMD_IMAGE, 0, 0, 0, 0, 32'hFFFF_FFFF);
        push_cmd(CMD_IMAGE, 5, 5, 0, 0, 32'hFFFF_FF00);
        push_cmd(CMD_IMAGE, 4095, 4095, 4095, 4095, 32'h5555_5555);
        push_cmd(CMD_IMAGE, 1919, 1079, 0, 0, 32'h0000_0001);
        push_cmd(CMD_IMAGE, 1920, 0, 0, 0, 32'hAAAA_AAAA);
        push_cmd(CMD_IMAGE, 7, 1080, 0, 0, 32'h0000_0000);
        // A 2 by 2 rectangle on the bottom-right corner. Three of its pixels
        // are off screen, the last one among them.
        push_cmd(CMD_START, 1919, 1079, 1, 1, 0);
        repeat (4) push_cmd(CMD_STEP, 0, 0, 0, 0, 0);
        // The largest rectangle at the far corner. It is dropped after two
        // steps when a one-pixel rectangle starts over it.
        push_cmd(CMD_START, 4095, 4095, 4095, 4095, 0);
        push_cmd(CMD_STEP, 4095, 4095, 4095, 4095, 32'hFFFF_FFFF);
        push_cmd(CMD_IMAGE, 100, 200, 0, 0, 32'h0000_0080);
        push_cmd(CMD_STEP, 0, 0, 0, 0, 0);
        push_cmd(CMD_START, 10, 20, 0, 0, 0);
        push_cmd(CMD_STEP, 0, 0, 0, 0, 0);
        push_cmd(CMD_STEP, 0, 0, 0, 0, 0);
        // A rectangle that crosses the top of the coordinate range in x.
        push_cmd(CMD_START, 4094, 3, 3, 0, 0);
        repeat (4) push_cmd(CMD_STEP, 0, 0, 0, 0, 0);
        wait_until_quiet();

        // Random traffic in six settings. Idling goes from a slow sender with a
        // stalling receiver, to the other way round, to none at all. In each
        // setting the sender stops halfway until every write is back.
        for (seg = 0; seg < 6; seg++) begin
            case (seg)
                0: apply_setting(FMT_RGB, 40, 30, 8191, 1'b0, 32'hFFFF_FF00, 32'hFF_FFFF);
                1: apply_setting(!FMT_RGB, 4095, 4095, 0, 1'b0, 32'h0, 32'h0);
                2: apply_setting(FMT_RGB, 0, 0, 123, 1'b1, 32'h8000_0000, 32'h00_FF00);
                4: apply_setting(!FMT_RGB, 4095, 17, 4096, 1'b1, 32'hFFFF_FFFF, 32'hA5_A5A5);
                default: apply_setting(1'($urandom_range(0, 1)), $urandom_range(1, 80),
                                       $urandom_range(1, 80), $urandom_range(0, 8191),
                                       1'($urandom_range(0, 1)), $urandom,
                                       $urandom_range(0, 24'hFF_FFFF));
            endcase
            send_idle_pct = (seg < 2) ? 28 : (seg < 4) ? 87 : 0;
            recv_idle_pct = (seg < 2) ? 87 : (seg < 4) ? 28 : 0;
            queue_random_traffic(SEG_ITEMS / 2);
            wait_until_quiet();
            queue_random_traffic(SEG_ITEMS - SEG_ITEMS / 2);
            wait_until_quiet();
        end

        // Every command has gone in by now. Writes still owed after a
        // generous wait count as failures.
        guard = 0;
        while (pending_writes.size() != 0 && guard < END_GRACE) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (6) @(negedge i_clk);
        if (pending_writes.size() != 0)
            log_mismatch("writes never delivered", pending_writes.size(), 0);

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
